FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define UDM_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("udp demux table check failed");

// Check a property on every clock edge, reset included.
`define UDM_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("udp demux table check failed");

`endif

FILE: sv/udpdmx_pkg.sv
`timescale 1ns / 1ps
package udpdmx_pkg;

   localparam logic [1:0] CMD_BIND    = 2'd0;
   localparam logic [1:0] CMD_CONNECT = 2'd1;
   localparam logic [1:0] CMD_REMOVE  = 2'd2;
   localparam logic [1:0] CMD_LOOKUP  = 2'd3;

   localparam logic [1:0] STS_OK          = 2'd0;
   localparam logic [1:0] STS_UNREACHABLE = 2'd1;
   localparam logic [1:0] STS_SILENT      = 2'd2;
   localparam logic [1:0] STS_NO_SLOT     = 2'd3;

   localparam logic [15:0] EPH_BASE = 16'd4096;
   localparam logic [15:0] EPH_TOP  = 16'h7FFF;

   localparam logic [31:0] NETMASK_RESET = 32'hFFFF_FF00;

   // One endpoint slot as kept in the slot memory.
   typedef struct packed {
      logic [31:0] laddr;
      logic [15:0] lport;
      logic [31:0] paddr;
      logic [15:0] pport;
   } slot_rec_type;

endpackage

FILE: sv/udp_port_demux_table_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// UDP endpoint demultiplex table. Start a command (bind, connect, remove or
// lookup) by raising start while busy is low; busy then stays high until the
// single result has been shown on the rsp_ ports for one cycle with rsp_valid
// high. The receiver cannot stall, so capture the result in that cycle.
// One shared compare unit walks the tables through memories with one read and
// one write port each. Lookup reads the linked slots in search order and stops
// early on a full match. Bind and connect write the slot; a newly linked slot
// is put at the front of the search order, and a local port of 0 gets an
// ephemeral port, each candidate compared against every linked slot. Remove
// walks the search order only when the slot was linked. There is no clearing
// pass after reset: per-slot linked bits mark valid memory entries.
// The netmask register may be written at any time csr_ready is high; write it
// only while the block is idle.
module udp_port_demux_table_core
   import udpdmx_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_slot,
   input  logic [31:0] req_own_addr,
   input  logic [15:0] req_own_port,
   input  logic [31:0] req_peer_addr,
   input  logic [15:0] req_peer_port,
   // result channel
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_hit_slot,
   output logic [15:0] rsp_bound_port,
   // netmask register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata
);

   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int TW = $clog2(SLOTS + 3);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SELF     = 4'd1;
   localparam logic [3:0] ST_EPH_NEXT = 4'd2;
   localparam logic [3:0] ST_EPH_RD   = 4'd3;
   localparam logic [3:0] ST_EPH_CMP  = 4'd4;
   localparam logic [3:0] ST_WRITE    = 4'd5;
   localparam logic [3:0] ST_LNK_RD   = 4'd6;
   localparam logic [3:0] ST_LNK_WR   = 4'd7;
   localparam logic [3:0] ST_LNK_TOP  = 4'd8;
   localparam logic [3:0] ST_UNL_RD   = 4'd9;
   localparam logic [3:0] ST_UNL_WR   = 4'd10;
   localparam logic [3:0] ST_LK_ORD   = 4'd11;
   localparam logic [3:0] ST_LK_SLOT  = 4'd12;
   localparam logic [3:0] ST_LK_CMP   = 4'd13;
   localparam logic [3:0] ST_DONE     = 4'd14;

   // control state
   logic [3:0]       state_ff, state_in;
   logic [SLOTS-1:0] linked_ff, linked_in;
   logic [SLOTS-1:0] conn_ff, conn_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [15:0]      eph_ff, eph_in;
   logic [31:0]      netmask_ff;

   // per-command working registers
   logic [1:0]       cmd_ff, cmd_in;
   logic [3:0]       slot_ff, slot_in;
   logic [31:0]      lip_ff, lip_in;
   logic [15:0]      lport_ff, lport_in;
   logic [31:0]      rip_ff, rip_in;
   logic [15:0]      rport_ff, rport_in;
   slot_rec_type     rec_ff, rec_in;
   logic [CW-1:0]    i_ff, i_in;
   logic [CW-1:0]    j_ff, j_in;
   logic [SW-1:0]    idx_ff, idx_in;
   logic [TW-1:0]    tries_ff, tries_in;
   logic [SW-1:0]    t_ff, t_in;
   logic             p2_hit_ff, p2_hit_in;
   logic [SW-1:0]    p2_slot_ff, p2_slot_in;
   logic [1:0]       status_ff, status_in;
   logic [3:0]       hit_ff, hit_in;
   logic [15:0]      bport_ff, bport_in;

   // memories
   slot_rec_type     slot_mem [SLOTS];
   logic [SW-1:0]    order_mem [SLOTS];
   slot_rec_type     slot_rd_ff;
   logic [SW-1:0]    order_rd_ff;
   logic [SW-1:0]    slot_raddr;
   logic             slot_we;
   logic [SW-1:0]    order_raddr;
   logic             order_we;
   logic [SW-1:0]    order_waddr;
   logic [SW-1:0]    order_wdata;

   logic [SW-1:0]    sidx;
   logic [CW-1:0]    i_inc;
   logic [15:0]      eph_step;
   slot_rec_type     self_rec;
   logic             addr_ok;
   logic             full_hit;
   logic             part_hit;
   logic [31:0]      host_bits;
   logic             dst_silent;

   assign sidx      = SW'(slot_ff);
   assign i_inc     = i_ff + CW'(1);
   assign eph_step  = (eph_ff + 16'd1 > EPH_TOP) ? EPH_BASE : eph_ff + 16'd1;
   assign self_rec  = linked_ff[sidx] ? slot_rd_ff : '0;

   // shared compare unit over the entry just read
   assign addr_ok  = (slot_rd_ff.paddr == 32'd0 || slot_rd_ff.paddr == rip_ff) &&
                     (slot_rd_ff.laddr == 32'd0 || slot_rd_ff.laddr == lip_ff);
   assign full_hit = slot_rd_ff.pport == rport_ff && slot_rd_ff.lport == lport_ff &&
                     addr_ok;
   assign part_hit = !conn_ff[t_ff] && slot_rd_ff.lport == lport_ff && addr_ok;

   // broadcast, multicast or all-zero destinations miss silently
   assign host_bits  = ~netmask_ff;
   assign dst_silent = (lip_ff & host_bits) == host_bits || lip_ff == 32'hFFFF_FFFF ||
                       lip_ff == 32'd0 || lip_ff[31:28] == 4'hE;

   always_comb begin
      slot_raddr = idx_ff;
      case (state_ff)
         ST_IDLE:    slot_raddr = SW'(req_slot);
         ST_LK_SLOT: slot_raddr = order_rd_ff;
         default:    slot_raddr = idx_ff;
      endcase
   end

   assign order_raddr = (state_ff == ST_LNK_RD) ? SW'(i_ff - CW'(1)) : SW'(i_ff);

   assign slot_we = state_ff == ST_WRITE;

   always_comb begin
      order_we    = 1'b0;
      order_waddr = SW'(i_ff);
      order_wdata = order_rd_ff;
      case (state_ff)
         ST_LNK_WR: begin
            order_we = 1'b1;
         end
         ST_LNK_TOP: begin
            order_we    = 1'b1;
            order_waddr = '0;
            order_wdata = sidx;
         end
         ST_UNL_WR: begin
            order_we    = order_rd_ff != sidx;
            order_waddr = SW'(j_ff);
         end
         default: order_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[sidx] <= rec_ff;
      end
      slot_rd_ff <= slot_mem[slot_raddr];
   end

   always_ff @(posedge clock) begin
      if (order_we) begin
         order_mem[order_waddr] <= order_wdata;
      end
      order_rd_ff <= order_mem[order_raddr];
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      linked_in  = linked_ff;
      conn_in    = conn_ff;
      cnt_in     = cnt_ff;
      eph_in     = eph_ff;
      cmd_in     = cmd_ff;
      slot_in    = slot_ff;
      lip_in     = lip_ff;
      lport_in   = lport_ff;
      rip_in     = rip_ff;
      rport_in   = rport_ff;
      rec_in     = rec_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      idx_in     = idx_ff;
      tries_in   = tries_ff;
      t_in       = t_ff;
      p2_hit_in  = p2_hit_ff;
      p2_slot_in = p2_slot_ff;
      status_in  = status_ff;
      hit_in     = hit_ff;
      bport_in   = bport_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in    = req_command;
               slot_in   = req_slot;
               lip_in    = req_own_addr;
               lport_in  = req_own_port;
               rip_in    = req_peer_addr;
               rport_in  = req_peer_port;
               status_in = STS_OK;
               hit_in    = req_slot;
               bport_in  = 16'd0;
               i_in      = '0;
               j_in      = '0;
               p2_hit_in = 1'b0;
               if (req_command == CMD_LOOKUP) begin
                  hit_in   = 4'd0;
                  state_in = (cnt_ff == '0) ? ST_LK_CMP : ST_LK_ORD;
               end else if (32'(req_slot) >= SLOTS) begin
                  status_in = STS_NO_SLOT;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_SELF;
               end
            end
         end

         ST_SELF: begin
            rec_in = self_rec;
            case (cmd_ff)
               CMD_BIND: begin
                  rec_in.laddr = lip_ff;
                  rec_in.lport = lport_ff;
                  state_in     = (lport_ff == 16'd0) ? ST_EPH_NEXT : ST_WRITE;
               end
               CMD_CONNECT: begin
                  rec_in.paddr = rip_ff;
                  rec_in.pport = rport_ff;
                  state_in     = (self_rec.lport == 16'd0) ? ST_EPH_NEXT : ST_WRITE;
               end
               default: begin
                  // remove: the linked bit alone voids the memory entry
                  if (linked_ff[sidx]) begin
                     state_in = ST_UNL_RD;
                  end else begin
                     conn_in[sidx] = 1'b0;
                     state_in      = ST_DONE;
                  end
               end
            endcase
            tries_in = '0;
         end

         ST_EPH_NEXT: begin
            eph_in   = eph_step;
            tries_in = tries_ff + TW'(1);
            idx_in   = '0;
            state_in = ST_EPH_RD;
         end

         ST_EPH_RD: begin
            state_in = ST_EPH_CMP;
         end

         ST_EPH_CMP: begin
            if (linked_ff[idx_ff] && slot_rd_ff.lport == eph_ff) begin
               if (tries_ff == TW'(SLOTS + 2)) begin
                  rec_in.lport = eph_ff;
                  state_in     = ST_WRITE;
               end else begin
                  state_in = ST_EPH_NEXT;
               end
            end else if (idx_ff == SW'(SLOTS - 1)) begin
               rec_in.lport = eph_ff;
               state_in     = ST_WRITE;
            end else begin
               idx_in   = idx_ff + SW'(1);
               state_in = ST_EPH_RD;
            end
         end

         ST_WRITE: begin
            bport_in = rec_ff.lport;
            if (cmd_ff == CMD_CONNECT) begin
               conn_in[sidx] = 1'b1;
            end
            if (!linked_ff[sidx]) begin
               linked_in[sidx] = 1'b1;
               i_in            = cnt_ff;
               state_in        = (cnt_ff == '0) ? ST_LNK_TOP : ST_LNK_RD;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_LNK_RD: begin
            state_in = ST_LNK_WR;
         end

         ST_LNK_WR: begin
            i_in     = i_ff - CW'(1);
            state_in = (i_ff == CW'(1)) ? ST_LNK_TOP : ST_LNK_RD;
         end

         ST_LNK_TOP: begin
            cnt_in   = cnt_ff + CW'(1);
            state_in = ST_DONE;
         end

         ST_UNL_RD: begin
            state_in = ST_UNL_WR;
         end

         ST_UNL_WR: begin
            if (order_rd_ff != sidx) begin
               j_in = j_ff + CW'(1);
            end
            i_in = i_inc;
            if (i_inc == cnt_ff) begin
               cnt_in          = cnt_ff - CW'(1);
               linked_in[sidx] = 1'b0;
               conn_in[sidx]   = 1'b0;
               state_in        = ST_DONE;
            end else begin
               state_in = ST_UNL_RD;
            end
         end

         ST_LK_ORD: begin
            state_in = ST_LK_SLOT;
         end

         ST_LK_SLOT: begin
            t_in     = order_rd_ff;
            state_in = ST_LK_CMP;
         end

         ST_LK_CMP: begin
            i_in = i_inc;
            if (cnt_ff != '0 && full_hit) begin
               hit_in   = 4'(t_ff);
               bport_in = slot_rd_ff.lport;
               state_in = ST_DONE;
            end else begin
               if (cnt_ff != '0 && part_hit && !p2_hit_ff) begin
                  p2_hit_in  = 1'b1;
                  p2_slot_in = t_ff;
               end
               if (cnt_ff == '0 || i_inc == cnt_ff) begin
                  state_in = ST_DONE;
                  if (cnt_ff != '0 && part_hit && !p2_hit_ff) begin
                     hit_in   = 4'(t_ff);
                     bport_in = slot_rd_ff.lport;
                  end else if (p2_hit_ff) begin
                     // the partial-match port is the lookup port itself
                     hit_in   = 4'(p2_slot_ff);
                     bport_in = lport_ff;
                  end else begin
                     status_in = dst_silent ? STS_SILENT : STS_UNREACHABLE;
                  end
               end else begin
                  state_in = ST_LK_ORD;
               end
            end
         end

         ST_DONE: begin
            state_in = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         linked_ff  <= '0;
         conn_ff    <= '0;
         cnt_ff     <= '0;
         eph_ff     <= EPH_BASE;
         netmask_ff <= NETMASK_RESET;
      end else begin
         state_ff  <= state_in;
         linked_ff <= linked_in;
         conn_ff   <= conn_in;
         cnt_ff    <= cnt_in;
         eph_ff    <= eph_in;
         if (csr_valid && csr_ready) begin
            netmask_ff <= csr_wdata;
         end
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      slot_ff    <= slot_in;
      lip_ff     <= lip_in;
      lport_ff   <= lport_in;
      rip_ff     <= rip_in;
      rport_ff   <= rport_in;
      rec_ff     <= rec_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      idx_ff     <= idx_in;
      tries_ff   <= tries_in;
      t_ff       <= t_in;
      p2_hit_ff  <= p2_hit_in;
      p2_slot_ff <= p2_slot_in;
      status_ff  <= status_in;
      hit_ff     <= hit_in;
      bport_ff   <= bport_in;
   end

   assign busy           = state_ff != ST_IDLE;
   assign rsp_valid      = state_ff == ST_DONE;
   assign rsp_status     = status_ff;
   assign rsp_hit_slot   = hit_ff;
   assign rsp_bound_port = bport_ff;
   assign csr_ready      = 1'b1;

   `UDM_ASSERT(a_single_strobe, rsp_valid |=> !rsp_valid && !busy)
   `UDM_ASSERT(a_start_takes, (start && !busy) |=> busy)
   `UDM_ASSERT(a_count_bound, cnt_ff <= CW'(SLOTS))
   `UDM_ASSERT(a_count_matches, (state_ff == ST_IDLE) |-> $countones(linked_ff) == int'(cnt_ff))
   `UDM_ASSERT_ALWAYS(a_reset_idle, reset |=> !busy)

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import udpdmx_pkg::*;

   localparam int NSLOT = 16;
   localparam int CYCLE_LIMIT = 6_000_000;
   localparam int ITEMS_PER_PHASE = 290;

   // One command as the block takes it.
   typedef struct {
      logic [1:0]  command;
      logic [3:0]  slot;
      logic [31:0] own_addr;
      logic [15:0] own_port;
      logic [31:0] peer_addr;
      logic [15:0] peer_port;
   } command_item_type;

   // One reply as the block shows it.
   typedef struct {
      logic [1:0]  status;
      logic [3:0]  hit_slot;
      logic [15:0] bound_port;
   } reply_item_type;

   // Mirror of the endpoint table; predicts the reply of every accepted command
   // and holds the replies still owed by the block.
   class demux_table_tracker_type;
      bit             linked[NSLOT];
      bit             connected[NSLOT];
      logic [31:0]    laddr[NSLOT];
      logic [15:0]    lport[NSLOT];
      logic [31:0]    paddr[NSLOT];
      logic [15:0]    pport[NSLOT];
      int             recent_first[$];
      logic [15:0]    eph_port;
      logic [31:0]    netmask;
      reply_item_type pending_replies[$];
      int             mismatches;

      function new();
         netmask = NETMASK_RESET;
         eph_port = EPH_BASE;
         mismatches = 0;
         for (int i = 0; i < NSLOT; i++) begin
            linked[i] = 0; connected[i] = 0;
            laddr[i] = '0; lport[i] = '0; paddr[i] = '0; pport[i] = '0;
         end
      endfunction

      function bit port_taken(logic [15:0] p);
         foreach (recent_first[i])
            if (lport[recent_first[i]] == p) return 1;
         return 0;
      endfunction

      // Step the ephemeral counter past ports held by linked slots.
      function logic [15:0] allocate_port();
         for (int tries = 0; tries <= NSLOT + 1; tries++) begin
            eph_port = (eph_port >= EPH_TOP) ? EPH_BASE : eph_port + 16'd1;
            if (!port_taken(eph_port)) break;
         end
         return eph_port;
      endfunction

      function bit addr_match(int s, logic [31:0] dst, logic [31:0] src);
         return (paddr[s] == 0 || paddr[s] == src) && (laddr[s] == 0 || laddr[s] == dst);
      endfunction

      function void note_command(command_item_type c);
         reply_item_type r;
         int s, found;
         s = c.slot;
         r.status = STS_OK; r.hit_slot = c.slot; r.bound_port = '0;
         case (c.command)
            CMD_LOOKUP: begin
               found = -1;
               // full match first, then the first unconnected slot on the local port
               foreach (recent_first[i]) begin
                  if (found < 0 && pport[recent_first[i]] == c.peer_port &&
                      lport[recent_first[i]] == c.own_port &&
                      addr_match(recent_first[i], c.own_addr, c.peer_addr))
                     found = recent_first[i];
               end
               foreach (recent_first[i]) begin
                  if (found < 0 && !connected[recent_first[i]] &&
                      lport[recent_first[i]] == c.own_port &&
                      addr_match(recent_first[i], c.own_addr, c.peer_addr))
                     found = recent_first[i];
               end
               if (found >= 0) begin
                  r.hit_slot = 4'(found);
                  r.bound_port = lport[found];
               end else begin
                  r.hit_slot = '0;
                  if ((c.own_addr & ~netmask) == ~netmask || c.own_addr == 32'hFFFF_FFFF ||
                      c.own_addr == 0 || c.own_addr[31:28] == 4'b1110)
                     r.status = STS_SILENT;
                  else
                     r.status = STS_UNREACHABLE;
               end
            end
            CMD_BIND: begin
               laddr[s] = c.own_addr;
               lport[s] = (c.own_port != 0) ? c.own_port : allocate_port();
               if (!linked[s]) begin recent_first.push_front(s); linked[s] = 1; end
               r.bound_port = lport[s];
            end
            CMD_CONNECT: begin
               paddr[s] = c.peer_addr;
               pport[s] = c.peer_port;
               connected[s] = 1;
               if (lport[s] == 0) lport[s] = allocate_port();
               if (!linked[s]) begin recent_first.push_front(s); linked[s] = 1; end
               r.bound_port = lport[s];
            end
            default: begin
               for (int i = recent_first.size() - 1; i >= 0; i--)
                  if (recent_first[i] == s) recent_first.delete(i);
               linked[s] = 0; connected[s] = 0;
               laddr[s] = '0; lport[s] = '0; paddr[s] = '0; pport[s] = '0;
            end
         endcase
         pending_replies.push_back(r);
      endfunction

      function void check_response(reply_item_type got);
         reply_item_type want;
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected reply: status %0d slot %0d port %0d",
                        got.status, got.hit_slot, got.bound_port);
            return;
         end
         want = pending_replies.pop_front();
         if (got.status !== want.status || got.hit_slot !== want.hit_slot ||
             got.bound_port !== want.bound_port) begin
            mismatches++;
            if (mismatches <= 10)
               $display("reply mismatch: expected status %0d slot %0d port %0d, got %0d %0d %0d",
                        want.status, want.hit_slot, want.bound_port,
                        got.status, got.hit_slot, got.bound_port);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_command = CMD_LOOKUP;
   logic [3:0]  req_slot = '0;
   logic [31:0] req_own_addr = '0;
   logic [15:0] req_own_port = '0;
   logic [31:0] req_peer_addr = '0;
   logic [15:0] req_peer_port = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_hit_slot;
   logic [15:0] rsp_bound_port;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [31:0] csr_wdata = '0;

   demux_table_tracker_type table_mirror = new();
   int  cycle_count = 0;
   bit  no_idle = 0;   // set for stretches without gaps

   udp_port_demux_table_core i_dut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_command(req_command), .req_slot(req_slot),
      .req_own_addr(req_own_addr), .req_own_port(req_own_port),
      .req_peer_addr(req_peer_addr), .req_peer_port(req_peer_port),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_hit_slot(rsp_hit_slot), .rsp_bound_port(rsp_bound_port),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Watchdog: end the run if the block stops answering.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Check the reply first, then note a command taken at this edge.
   always @(posedge clock) begin
      reply_item_type got;
      command_item_type c;
      if (!reset) begin
         if (rsp_valid) begin
            got.status = rsp_status;
            got.hit_slot = rsp_hit_slot;
            got.bound_port = rsp_bound_port;
            table_mirror.check_response(got);
         end
         if (start && !busy) begin
            c.command = req_command; c.slot = req_slot;
            c.own_addr = req_own_addr; c.own_port = req_own_port;
            c.peer_addr = req_peer_addr; c.peer_port = req_peer_port;
            table_mirror.note_command(c);
         end
      end
   end

   // Mostly no or short gaps, a few long ones, none during no_idle stretches.
   function int gap_length();
      int roll;
      roll = $urandom_range(99);
      if (no_idle || roll < 65) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 20);
      return $urandom_range(30, 80);
   endfunction

   // Present one command and hold it until the block takes it.
   task automatic issue(command_item_type c);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         @(negedge clock);
         start <= 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1;
      req_command <= c.command; req_slot <= c.slot;
      req_own_addr <= c.own_addr; req_own_port <= c.own_port;
      req_peer_addr <= c.peer_addr; req_peer_port <= c.peer_port;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
   endtask

   task automatic drop_start();
      @(negedge clock);
      start <= 0;
   endtask

   task automatic issue_fields(logic [1:0] cmd, int s, logic [31:0] lip, logic [15:0] lp,
                               logic [31:0] rip, logic [15:0] rp);
      command_item_type c;
      c.command = cmd; c.slot = 4'(s); c.own_addr = lip; c.own_port = lp;
      c.peer_addr = rip; c.peer_port = rp;
      issue(c);
   endtask

   // Wait for every owed reply, then let the block settle.
   task automatic drain();
      drop_start();
      while (table_mirror.pending_replies.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_netmask(logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1;
      csr_wdata <= value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      table_mirror.netmask = value;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function logic [15:0] pick_port();
      case ($urandom_range(7))
         0: return 16'd0;
         1: return 16'd53;
         2: return 16'hFFFF;
         3: return 16'h8000;
         4, 5: return 16'($urandom_range(4097, 4104));
         default: return 16'($urandom);
      endcase
   endfunction

   function logic [31:0] pick_addr();
      case ($urandom_range(7))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'hE000_0001;
         3: return 32'h0A00_00FF;
         4, 5: return 32'h0A00_0000 | $urandom_range(1, 4);
         default: return $urandom;
      endcase
   endfunction

   // Build a random command; most lookups aim at a live slot.
   function command_item_type random_command();
      command_item_type c;
      int roll, s;
      roll = $urandom_range(99);
      c.slot = 4'($urandom_range(NSLOT - 1));
      c.own_addr = pick_addr(); c.own_port = pick_port();
      c.peer_addr = pick_addr(); c.peer_port = pick_port();
      if (roll < 12) begin
         c.command = CMD_BIND;
         if ($urandom_range(3) == 0) c.own_port = '0;
      end else if (roll < 20) c.command = CMD_CONNECT;
      else if (roll < 27) c.command = CMD_REMOVE;
      else begin
         c.command = CMD_LOOKUP;
         if (table_mirror.recent_first.size() != 0 && $urandom_range(99) < 65) begin
            s = table_mirror.recent_first[$urandom_range(table_mirror.recent_first.size() - 1)];
            c.own_port = table_mirror.lport[s];
            c.peer_port = table_mirror.pport[s];
            if (table_mirror.laddr[s] != 0) c.own_addr = table_mirror.laddr[s];
            if (table_mirror.paddr[s] != 0) c.peer_addr = table_mirror.paddr[s];
            // perturb one field now and then to hit the second pass or a miss
            case ($urandom_range(7))
               0: c.peer_port = 16'($urandom);
               1: c.peer_addr = $urandom;
               2: c.own_addr = $urandom;
               default: ;
            endcase
         end
      end
      return c;
   endfunction

   initial begin
      logic [31:0] masks[5];
      masks = '{32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_0000, 32'h0};
      masks[4] = $urandom;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      write_netmask(masks[0]);
      // Directed: empty table, allocation with collisions, both lookup passes.
      issue_fields(CMD_LOOKUP, 0, 32'h0, 16'd7, 32'h0A00_0001, 16'd9);
      issue_fields(CMD_LOOKUP, 0, 32'h0A00_0002, 16'd7, 32'h0A00_0001, 16'd9);
      issue_fields(CMD_BIND, 1, 32'h0, 16'd4098, 32'h0, 16'd0);
      issue_fields(CMD_BIND, 2, 32'h0, 16'd4099, 32'h0, 16'd0);
      issue_fields(CMD_BIND, 0, 32'h0A00_0002, 16'd0, 32'h0, 16'd0);
      issue_fields(CMD_BIND, 3, 32'h0, 16'd0, 32'h0, 16'd0);
      issue_fields(CMD_CONNECT, 4, 32'h0, 16'd0, 32'h0A00_0009, 16'd80);
      issue_fields(CMD_CONNECT, 0, 32'h0, 16'd0, 32'hFFFF_FFFF, 16'hFFFF);
      issue_fields(CMD_BIND, 15, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
      issue_fields(CMD_BIND, 5, 32'h0, 16'd4098, 32'h0, 16'd0);
      issue_fields(CMD_LOOKUP, 9, 32'h0A00_0005, 16'd4098, 32'h0A00_0001, 16'd1);
      issue_fields(CMD_LOOKUP, 0, 32'h0A00_0002, 16'd4097, 32'hFFFF_FFFF, 16'hFFFF);
      issue_fields(CMD_LOOKUP, 0, 32'h0A00_0003, 16'd4097, 32'hFFFF_FFFF, 16'hFFFF);
      issue_fields(CMD_LOOKUP, 0, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'hFFFF);
      issue_fields(CMD_LOOKUP, 0, 32'hE100_0001, 16'd1, 32'h1, 16'd1);
      issue_fields(CMD_LOOKUP, 0, 32'h0A00_00FF, 16'd1, 32'h1, 16'd1);
      issue_fields(CMD_LOOKUP, 0, 32'hFFFF_FFFF, 16'd1, 32'h1, 16'd1);
      issue_fields(CMD_REMOVE, 1, 32'h0, 16'd0, 32'h0, 16'd0);
      issue_fields(CMD_REMOVE, 12, 32'h0, 16'd0, 32'h0, 16'd0);
      issue_fields(CMD_BIND, 1, 32'h0, 16'd0, 32'h0, 16'd0);
      issue_fields(CMD_BIND, 1, 32'h0A00_0004, 16'd4098, 32'h0, 16'd0);
      issue_fields(CMD_LOOKUP, 0, 32'h0A00_0004, 16'd4098, 32'h0A00_0001, 16'd1);

      // Random phases, each under its own netmask.
      foreach (masks[p]) begin
         if (p != 0) begin
            drain();
            write_netmask(masks[p]);
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 50 == 0) no_idle = ($urandom_range(3) == 0);
            issue(random_command());
         end
      end
      drain();

      if (table_mirror.mismatches == 0 && table_mirror.pending_replies.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
